[design/cvst_pkg.sv]
package cvst_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int LEVEL_W   = 6;
  localparam int THR_W     = 4;
  localparam int CFG_W     = 11;
  localparam int PERIOD_W  = 11;
  localparam int LINE_W    = 9;
  localparam int PLEN_W    = 16;
  localparam int STAT_W    = 32;
  localparam int OUT_IDX_W = 48;
  localparam int REG_IDX_W = 3;
  localparam int RELEASE_W = 10;

  localparam int DEF_INDEX_BITS   = 48;
  localparam int DEF_LOCK_EVENTS  = 3;
  localparam int DEF_CLUSTER_LINES = 4;
  localparam int DEF_TIMEOUT_LINES = 3;

  localparam logic [LEVEL_W-1:0] FLOOR_RESET = 6'd8;
  localparam logic [LEVEL_W-1:0] PEAK_RESET  = 6'd24;
  localparam logic [LEVEL_W-1:0] FLOOR_REST  = 6'd8;
  localparam logic [LEVEL_W-1:0] PEAK_REST   = 6'd20;
  localparam logic [LEVEL_W-1:0] SPAN_FLAT   = 6'd8;
  localparam logic [THR_W-1:0]   THR_MIN     = 4'd4;
  localparam logic [THR_W-1:0]   THR_MAX     = 4'd14;
  localparam logic [LEVEL_W-1:0] THR_MARGIN  = 6'd2;

  localparam logic [CFG_W-1:0]    HSYNC_MIN_RESET = 11'd60;
  localparam logic [CFG_W-1:0]    HSYNC_MAX_RESET = 11'd160;
  localparam logic [CFG_W-1:0]    BROAD_MIN_RESET = 11'd300;
  localparam logic [CFG_W-1:0]    BROAD_MAX_RESET = 11'd800;
  localparam logic [CFG_W-1:0]    LINE_MIN_RESET  = 11'd1100;
  localparam logic [CFG_W-1:0]    LINE_MAX_RESET  = 11'd1450;
  localparam logic [PERIOD_W-1:0] NOMINAL_RESET   = 11'd1280;
  localparam logic [LINE_W-1:0]   MAX_LINES_RESET = 9'd340;
  localparam logic [LINE_W-1:0]   NO_LINE         = 9'd511;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HSYNC_MIN = 3'd0,
    REG_HSYNC_MAX = 3'd1,
    REG_BROAD_MIN = 3'd2,
    REG_BROAD_MAX = 3'd3,
    REG_LINE_MIN  = 3'd4,
    REG_LINE_MAX  = 3'd5,
    REG_NOMINAL   = 3'd6,
    REG_MAX_LINES = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] video_sample;
  } sample_t;

  typedef struct packed {
    logic                 event_valid;
    logic                 vertical_sync;
    logic                 horizontal_sync;
    logic [OUT_IDX_W-1:0] sync_start_index;
    logic [OUT_IDX_W-1:0] current_sample_index;
    logic [PERIOD_W-1:0]  line_period;
    logic [LINE_W-1:0]    field_line_number;
    logic                 fully_locked;
    logic [STAT_W-1:0]    rejected_pulse_count;
    logic [STAT_W-1:0]    lock_loss_count;
    logic [STAT_W-1:0]    lock_gain_count;
  } result_t;

endpackage

[design/cvst_if.sv]
interface cvst_sample_if;
  logic              valid;
  logic              ready;
  cvst_pkg::sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cvst_result_if;
  logic              valid;
  logic              ready;
  cvst_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/cvst_envelope.sv]
module cvst_envelope (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [cvst_pkg::LEVEL_W-1:0]  level_i,
  input  logic                          release_i,
  output logic [cvst_pkg::THR_W-1:0]    thr_o
);

  logic [cvst_pkg::LEVEL_W-1:0] floor_q, floor_d;
  logic [cvst_pkg::LEVEL_W-1:0] peak_q, peak_d;
  logic [cvst_pkg::LEVEL_W-1:0] span;
  logic [cvst_pkg::LEVEL_W:0]   raw_thr;

  always_comb begin
    floor_d = (level_i < floor_q) ? level_i : floor_q;
    peak_d  = (level_i > peak_q) ? level_i : peak_q;
    if (release_i) begin
      if (floor_d < cvst_pkg::FLOOR_REST) begin
        floor_d = floor_d + 6'd1;
      end
      if (peak_d > cvst_pkg::PEAK_REST) begin
        peak_d = peak_d - 6'd1;
      end
    end
    span    = (peak_d > floor_d) ? (peak_d - floor_d) : cvst_pkg::SPAN_FLAT;
    raw_thr = {1'b0, floor_d} + {3'b000, span[cvst_pkg::LEVEL_W-1:2]};
    if (raw_thr < {3'b000, cvst_pkg::THR_MIN}) begin
      thr_o = cvst_pkg::THR_MIN;
    end else if (raw_thr > {3'b000, cvst_pkg::THR_MAX}) begin
      thr_o = cvst_pkg::THR_MAX;
    end else begin
      thr_o = raw_thr[cvst_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= cvst_pkg::FLOOR_RESET;
      peak_q  <= cvst_pkg::PEAK_RESET;
    end else if (en_i) begin
      floor_q <= floor_d;
      peak_q  <= peak_d;
    end
  end

endmodule

[design/composite_video_sync_tracker.sv]
// Composite video sync separator. One converter byte is taken per clock and
// every sample gives exactly one result beat in the cycle after acceptance, so
// the sustained rate is one sample per cycle; the single result register is
// the only buffer, and the input stalls only while that register holds a beat
// the sink has not taken. The low six bits drive a floor/peak envelope and a
// slicing threshold; a pulse closes after three samples above threshold + 2
// and is classed as broad (first of a cluster gives a vertical event),
// horizontal (line period smoothing, lock score, field line count) or
// rejected. Configuration writes take effect at once and are meant for idle
// time; writing the nominal line period also reloads the period estimate.
module composite_video_sync_tracker #(
  parameter int INDEX_BITS    = cvst_pkg::DEF_INDEX_BITS,
  parameter int LOCK_EVENTS   = cvst_pkg::DEF_LOCK_EVENTS,
  parameter int CLUSTER_LINES = cvst_pkg::DEF_CLUSTER_LINES,
  parameter int TIMEOUT_LINES = cvst_pkg::DEF_TIMEOUT_LINES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cvst_sample_if.sink                     sample_i,
  cvst_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [cvst_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [cvst_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int LS_W  = $clog2(LOCK_EVENTS + 1);
  localparam int CLU_W = cvst_pkg::PERIOD_W + $clog2(CLUSTER_LINES + 1);
  localparam int TMO_W = cvst_pkg::PERIOD_W + $clog2(TIMEOUT_LINES + 1);
  localparam logic [LS_W-1:0] LOCK_TARGET = LS_W'(LOCK_EVENTS);

  logic [cvst_pkg::CFG_W-1:0]  hmin_q, hmax_q, bmin_q, bmax_q, lmin_q, lmax_q;
  logic [cvst_pkg::LINE_W-1:0] maxl_q;

  logic [INDEX_BITS-1:0] count_q, begin_q, begin_d, prev_h_q, prev_h_d;
  logic [INDEX_BITS-1:0] prev_v_q, prev_v_d;
  logic                  in_pulse_q, in_pulse_d;
  logic [cvst_pkg::PLEN_W-1:0]   plen_q, plen_d;
  logic [1:0]                    streak_q, streak_d;
  logic                          vseen_q, vseen_d;
  logic [cvst_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [LS_W-1:0]               score_q, score_d;
  logic                          hlock_q, hlock_d, vlock_q, vlock_d;
  logic [cvst_pkg::LINE_W-1:0]   line_q, line_d;
  logic [cvst_pkg::STAT_W-1:0]   rej_q, rej_d, loss_q, loss_d, gain_q, gain_d;

  logic                 out_valid_q;
  cvst_pkg::result_t    res_q, res_d;
  logic                 accept;
  logic [cvst_pkg::LEVEL_W-1:0] level;
  logic [cvst_pkg::THR_W-1:0]   thr;
  logic [63:0]          count_ext, begin_ext;
  logic [CLU_W-1:0]     clu_lim;
  logic [TMO_W-1:0]     tmo_lim;

  logic                          close;
  logic [cvst_pkg::PLEN_W-1:0]   width;
  logic [INDEX_BITS-1:0]         gap_h, gap_v, iv;
  logic [13:0]                   avg_sum;
  logic [cvst_pkg::LINE_W:0]     line_nx;

  assign accept          = sample_i.valid && sample_i.ready;
  assign sample_i.ready  = !out_valid_q || result_o.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.payload = res_q;
  assign level     = sample_i.payload.video_sample[cvst_pkg::LEVEL_W-1:0];
  assign count_ext = 64'(count_q);
  assign begin_ext = 64'(begin_q);
  assign clu_lim   = CLU_W'(CLUSTER_LINES) * CLU_W'(period_q);
  assign tmo_lim   = TMO_W'(TIMEOUT_LINES) * TMO_W'(period_q);

  cvst_envelope u_envelope (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .level_i   (level),
    .release_i (count_q[cvst_pkg::RELEASE_W-1:0] == '0),
    .thr_o     (thr)
  );

  always_comb begin
    begin_d    = begin_q;
    prev_h_d   = prev_h_q;
    prev_v_d   = prev_v_q;
    in_pulse_d = in_pulse_q;
    plen_d     = plen_q;
    streak_d   = streak_q;
    vseen_d    = vseen_q;
    period_d   = period_q;
    score_d    = score_q;
    hlock_d    = hlock_q;
    vlock_d    = vlock_q;
    line_d     = line_q;
    rej_d      = rej_q;
    loss_d     = loss_q;
    gain_d     = gain_q;
    close      = 1'b0;
    width      = '0;
    gap_v      = prev_v_q;
    iv         = prev_h_q;
    avg_sum    = '0;
    line_nx    = '0;

    res_d = '0;
    res_d.current_sample_index = count_ext[cvst_pkg::OUT_IDX_W-1:0];
    res_d.field_line_number    = cvst_pkg::NO_LINE;

    // line timeout
    gap_h = count_q - prev_h_q;
    if (hlock_q && (prev_h_q != '0) && (gap_h > INDEX_BITS'(tmo_lim))) begin
      vlock_d = 1'b0;
      line_d  = cvst_pkg::NO_LINE;
      loss_d  = loss_d + 32'd1;
      hlock_d = 1'b0;
      score_d = '0;
    end

    if (!in_pulse_q) begin
      if ({2'b00, thr} >= level) begin
        in_pulse_d = 1'b1;
        begin_d    = count_q;
        plen_d     = 16'd1;
        streak_d   = 2'd0;
      end
    end else begin
      if (plen_q != '1) begin
        plen_d = plen_q + 16'd1;
      end
      if (level > ({2'b00, thr} + cvst_pkg::THR_MARGIN)) begin
        if (streak_q == 2'd2) begin
          close = 1'b1;
        end else begin
          streak_d = streak_q + 2'd1;
        end
      end else begin
        streak_d = 2'd0;
      end
    end

    if (close) begin
      width      = plen_d - 16'd3;
      in_pulse_d = 1'b0;
      plen_d     = '0;
      streak_d   = 2'd0;
      if ((width >= {5'd0, bmin_q}) && (width <= {5'd0, bmax_q})) begin
        gap_v = begin_q - prev_v_q;
        if (!(vseen_q && (gap_v < INDEX_BITS'(clu_lim)))) begin
          vseen_d  = 1'b1;
          prev_v_d = begin_q;
          vlock_d  = 1'b1;
          line_d   = '0;
          prev_h_d = '0;
          if (hlock_d) begin
            loss_d = loss_d + 32'd1;
          end
          hlock_d  = 1'b0;
          score_d  = '0;
          res_d.event_valid       = 1'b1;
          res_d.vertical_sync     = 1'b1;
          res_d.sync_start_index  = begin_ext[cvst_pkg::OUT_IDX_W-1:0];
          res_d.field_line_number = '0;
        end
      end else if ((width < {5'd0, hmin_q}) || (width > {5'd0, hmax_q})) begin
        rej_d = rej_d + 32'd1;
      end else begin
        if (prev_h_q != '0) begin
          iv = begin_q - prev_h_q;
          if ((iv >= INDEX_BITS'(lmin_q)) && (iv <= INDEX_BITS'(lmax_q))) begin
            avg_sum  = 14'(period_q) * 14'd7 + 14'(iv[cvst_pkg::PERIOD_W-1:0]) + 14'd4;
            period_d = avg_sum[13:3];
            if (score_d < LOCK_TARGET) begin
              score_d = score_d + LS_W'(1);
            end
          end else if (score_d != '0) begin
            score_d = score_d - LS_W'(1);
          end
        end
        if (!hlock_d && (score_d >= LOCK_TARGET)) begin
          hlock_d = 1'b1;
          gain_d  = gain_d + 32'd1;
        end else if (hlock_d && (score_d < LOCK_TARGET)) begin
          loss_d  = loss_d + 32'd1;
          hlock_d = 1'b0;
          score_d = '0;
        end
        prev_h_d = begin_q;

        res_d.event_valid       = 1'b1;
        res_d.horizontal_sync   = 1'b1;
        res_d.sync_start_index  = begin_ext[cvst_pkg::OUT_IDX_W-1:0];
        res_d.line_period       = period_d;
        res_d.field_line_number = vlock_d ? line_d : cvst_pkg::NO_LINE;
        res_d.fully_locked      = vlock_d && hlock_d;

        if (vlock_d) begin
          line_nx = {1'b0, line_d} + 10'd1;
          if ((line_nx > {1'b0, maxl_q}) || (line_nx >= {1'b0, cvst_pkg::NO_LINE})) begin
            vlock_d = 1'b0;
            line_d  = cvst_pkg::NO_LINE;
            if (hlock_d) begin
              loss_d = loss_d + 32'd1;
            end
            hlock_d = 1'b0;
            score_d = '0;
            res_d.fully_locked = 1'b0;
          end else begin
            line_d = line_nx[cvst_pkg::LINE_W-1:0];
          end
        end
      end
    end

    res_d.rejected_pulse_count = rej_d;
    res_d.lock_loss_count      = loss_d;
    res_d.lock_gain_count      = gain_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmin_q <= cvst_pkg::HSYNC_MIN_RESET;
      hmax_q <= cvst_pkg::HSYNC_MAX_RESET;
      bmin_q <= cvst_pkg::BROAD_MIN_RESET;
      bmax_q <= cvst_pkg::BROAD_MAX_RESET;
      lmin_q <= cvst_pkg::LINE_MIN_RESET;
      lmax_q <= cvst_pkg::LINE_MAX_RESET;
      maxl_q <= cvst_pkg::MAX_LINES_RESET;
    end else if (cfg_we_i) begin
      case (cvst_pkg::cfg_reg_e'(cfg_index_i))
        cvst_pkg::REG_HSYNC_MIN: hmin_q <= cfg_wdata_i;
        cvst_pkg::REG_HSYNC_MAX: hmax_q <= cfg_wdata_i;
        cvst_pkg::REG_BROAD_MIN: bmin_q <= cfg_wdata_i;
        cvst_pkg::REG_BROAD_MAX: bmax_q <= cfg_wdata_i;
        cvst_pkg::REG_LINE_MIN:  lmin_q <= cfg_wdata_i;
        cvst_pkg::REG_LINE_MAX:  lmax_q <= cfg_wdata_i;
        cvst_pkg::REG_MAX_LINES: maxl_q <= cfg_wdata_i[cvst_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      begin_q    <= '0;
      prev_h_q   <= '0;
      prev_v_q   <= '0;
      in_pulse_q <= 1'b0;
      plen_q     <= '0;
      streak_q   <= '0;
      vseen_q    <= 1'b0;
      period_q   <= cvst_pkg::NOMINAL_RESET;
      score_q    <= '0;
      hlock_q    <= 1'b0;
      vlock_q    <= 1'b0;
      line_q     <= cvst_pkg::NO_LINE;
      rej_q      <= '0;
      loss_q     <= '0;
      gain_q     <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == cvst_pkg::REG_NOMINAL)) begin
        period_q <= cfg_wdata_i;
      end else if (accept) begin
        period_q <= period_d;
      end
      if (accept) begin
        count_q    <= count_q + INDEX_BITS'(1);
        begin_q    <= begin_d;
        prev_h_q   <= prev_h_d;
        prev_v_q   <= prev_v_d;
        in_pulse_q <= in_pulse_d;
        plen_q     <= plen_d;
        streak_q   <= streak_d;
        vseen_q    <= vseen_d;
        score_q    <= score_d;
        hlock_q    <= hlock_d;
        vlock_q    <= vlock_d;
        line_q     <= line_d;
        rej_q      <= rej_d;
        loss_q     <= loss_d;
        gain_q     <= gain_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted sample produced no result beat");

  a_hlock_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hlock_q |-> (score_q == LOCK_TARGET))
    else $error("horizontal lock held without full score");

  a_line_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vlock_q == (line_q != cvst_pkg::NO_LINE))
    else $error("field line and vertical lock disagree");

  a_event_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.vertical_sync && res_q.horizontal_sync)
      && (!res_q.fully_locked || res_q.horizontal_sync))
    else $error("inconsistent event classification");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int IDX_W       = cvst_pkg::DEF_INDEX_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int PLEN_MAX    = 65535;
  localparam int SMP_W       = cvst_pkg::SAMPLE_W;
  localparam int LVL_W       = cvst_pkg::LEVEL_W;
  localparam int WD_W        = cvst_pkg::CFG_W;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [cvst_pkg::REG_IDX_W-1:0] cfg_index_i;
  logic [cvst_pkg::CFG_W-1:0] cfg_wdata_i;

  cvst_sample_if smp_if ();
  cvst_result_if res_if ();

  composite_video_sync_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (smp_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [cvst_pkg::SAMPLE_W-1:0] sample_q[$];
  cvst_pkg::result_t want_results[$];

  int src_idle_pct;
  int snk_idle_pct;
  int stall_cycles;
  int mismatches;
  int samples_made;
  int samples_sent;
  int beats_checked;
  int hsync_seen;
  int vsync_seen_cnt;
  int settings_used;

  // Tracker state
  int cfg_reg [8];
  int lvl_floor;
  int lvl_peak;
  int pulse_len;
  int rise_run;
  int period_est;
  int score;
  int line_no;
  logic [IDX_W-1:0] smp_cnt;
  logic [IDX_W-1:0] pulse_origin;
  logic [IDX_W-1:0] last_h;
  logic [IDX_W-1:0] last_v;
  bit in_pulse;
  bit v_seen;
  bit h_lock;
  bit v_lock;
  logic [cvst_pkg::STAT_W-1:0] n_rejected;
  logic [cvst_pkg::STAT_W-1:0] n_loss;
  logic [cvst_pkg::STAT_W-1:0] n_gain;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void release_hlock();
    if (h_lock) n_loss++;
    h_lock = 1'b0;
    score = 0;
  endfunction

  function automatic cvst_pkg::result_t track_sample(
      input logic [cvst_pkg::SAMPLE_W-1:0] raw);
    cvst_pkg::result_t r;
    logic [IDX_W-1:0] now;
    logic [IDX_W-1:0] gap;
    logic [IDX_W-1:0] start;
    int s;
    int span;
    int thr;
    int width;
    r = '0;
    r.field_line_number = cvst_pkg::NO_LINE;
    now = smp_cnt;
    r.current_sample_index = now;
    s = int'(raw[cvst_pkg::LEVEL_W-1:0]);

    if (s < lvl_floor) lvl_floor = s;
    if (s > lvl_peak) lvl_peak = s;
    if (now[cvst_pkg::RELEASE_W-1:0] == '0) begin
      if (lvl_floor < cvst_pkg::FLOOR_REST) lvl_floor++;
      if (lvl_peak > cvst_pkg::PEAK_REST) lvl_peak--;
    end
    span = (lvl_peak > lvl_floor) ? lvl_peak - lvl_floor : cvst_pkg::SPAN_FLAT;
    thr = lvl_floor + span / 4;
    if (thr < cvst_pkg::THR_MIN) thr = cvst_pkg::THR_MIN;
    if (thr > cvst_pkg::THR_MAX) thr = cvst_pkg::THR_MAX;

    gap = now - last_h;
    if (h_lock && last_h != '0 && gap > cvst_pkg::DEF_TIMEOUT_LINES * period_est) begin
      v_lock = 1'b0;
      line_no = cvst_pkg::NO_LINE;
      release_hlock();
    end

    if (!in_pulse) begin
      if (s <= thr) begin
        in_pulse = 1'b1;
        pulse_origin = now;
        pulse_len = 1;
        rise_run = 0;
      end
    end else begin
      if (pulse_len < PLEN_MAX) pulse_len++;
      if (s > thr + cvst_pkg::THR_MARGIN) begin
        rise_run++;
        if (rise_run >= 3) begin
          width = pulse_len - rise_run;
          start = pulse_origin;
          in_pulse = 1'b0;
          pulse_len = 0;
          rise_run = 0;
          if (width >= cfg_reg[cvst_pkg::REG_BROAD_MIN] &&
              width <= cfg_reg[cvst_pkg::REG_BROAD_MAX]) begin
            gap = start - last_v;
            if (!(v_seen && gap < cvst_pkg::DEF_CLUSTER_LINES * period_est)) begin
              v_seen = 1'b1;
              last_v = start;
              v_lock = 1'b1;
              line_no = 0;
              last_h = '0;
              release_hlock();
              r.event_valid = 1'b1;
              r.vertical_sync = 1'b1;
              r.sync_start_index = start;
              r.field_line_number = '0;
            end
          end else if (width < cfg_reg[cvst_pkg::REG_HSYNC_MIN] ||
                       width > cfg_reg[cvst_pkg::REG_HSYNC_MAX]) begin
            n_rejected++;
          end else begin
            if (last_h != '0) begin
              gap = start - last_h;
              if (gap >= cfg_reg[cvst_pkg::REG_LINE_MIN] &&
                  gap <= cfg_reg[cvst_pkg::REG_LINE_MAX]) begin
                period_est = (period_est * 7 + int'(gap) + 4) / 8;
                if (score < cvst_pkg::DEF_LOCK_EVENTS) score++;
              end else if (score != 0) begin
                score--;
              end
            end
            if (!h_lock && score >= cvst_pkg::DEF_LOCK_EVENTS) begin
              h_lock = 1'b1;
              n_gain++;
            end else if (h_lock && score < cvst_pkg::DEF_LOCK_EVENTS) begin
              release_hlock();
            end
            last_h = start;
            r.event_valid = 1'b1;
            r.horizontal_sync = 1'b1;
            r.sync_start_index = start;
            r.line_period = period_est[cvst_pkg::PERIOD_W-1:0];
            r.field_line_number = v_lock ? line_no[cvst_pkg::LINE_W-1:0]
                                         : cvst_pkg::NO_LINE;
            r.fully_locked = v_lock && h_lock;
            if (v_lock) begin
              line_no++;
              if (line_no > cfg_reg[cvst_pkg::REG_MAX_LINES] ||
                  line_no >= cvst_pkg::NO_LINE) begin
                v_lock = 1'b0;
                line_no = cvst_pkg::NO_LINE;
                release_hlock();
                r.fully_locked = 1'b0;
              end
            end
          end
        end
      end else begin
        rise_run = 0;
      end
    end
    smp_cnt = now + IDX_W'(1);
    r.rejected_pulse_count = n_rejected;
    r.lock_loss_count = n_loss;
    r.lock_gain_count = n_gain;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got, input logic [IDX_W-1:0] idx);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch at sample %0d, %s: expected %0h got %0h", idx, name, want, got);
      mismatches++;
    end
  endtask

  // Sample driver; also predicts the result beat of each accepted sample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_if.valid && smp_if.ready) begin
        want_results.push_back(track_sample(smp_if.payload.video_sample));
        samples_sent++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          smp_if.payload.video_sample <= sample_q.pop_front();
          smp_if.valid <= 1'b1;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; also drives the sink ready and the stall counter
  always @(posedge clk_i) begin : monitor
    cvst_pkg::result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (want_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat at sample %0d",
                     res_if.payload.current_sample_index);
          mismatches++;
        end else begin
          want = want_results.pop_front();
          beats_checked++;
          if (want.horizontal_sync) hsync_seen++;
          if (want.vertical_sync) vsync_seen_cnt++;
          compare_field("event_valid", want.event_valid, res_if.payload.event_valid,
                        want.current_sample_index);
          compare_field("vertical_sync", want.vertical_sync, res_if.payload.vertical_sync,
                        want.current_sample_index);
          compare_field("horizontal_sync", want.horizontal_sync,
                        res_if.payload.horizontal_sync, want.current_sample_index);
          compare_field("sync_start_index", want.sync_start_index,
                        res_if.payload.sync_start_index, want.current_sample_index);
          compare_field("current_sample_index", want.current_sample_index,
                        res_if.payload.current_sample_index, want.current_sample_index);
          compare_field("line_period", want.line_period, res_if.payload.line_period,
                        want.current_sample_index);
          compare_field("field_line_number", want.field_line_number,
                        res_if.payload.field_line_number, want.current_sample_index);
          compare_field("fully_locked", want.fully_locked, res_if.payload.fully_locked,
                        want.current_sample_index);
          compare_field("rejected_pulse_count", want.rejected_pulse_count,
                        res_if.payload.rejected_pulse_count, want.current_sample_index);
          compare_field("lock_loss_count", want.lock_loss_count,
                        res_if.payload.lock_loss_count, want.current_sample_index);
          compare_field("lock_gain_count", want.lock_gain_count,
                        res_if.payload.lock_gain_count, want.current_sample_index);
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else if (sample_q.size() != 0 || smp_if.valid || want_results.size() != 0) begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("composite_video_sync_tracker test failed");
    $finish;
  end

  task automatic push_run(input int n, input int lo, input int hi);
    logic [cvst_pkg::SAMPLE_W-1:0] b;
    repeat (n) begin
      b = SMP_W'($urandom_range(255));
      b[cvst_pkg::LEVEL_W-1:0] = LVL_W'($urandom_range(hi, lo));
      sample_q.push_back(b);
      samples_made++;
    end
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || smp_if.valid || want_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input int hmin, input int hmax, input int bmin,
                              input int bmax, input int lmin, input int lmax,
                              input int nom, input int maxl);
    int vals [8];
    vals = '{hmin, hmax, bmin, bmax, lmin, lmax, nom, maxl};
    for (int i = 0; i < $size(vals); i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= cvst_pkg::cfg_reg_e'(i);
      cfg_wdata_i <= WD_W'(vals[i]);
      cfg_reg[i] = vals[i];
      if (cvst_pkg::cfg_reg_e'(i) == cvst_pkg::REG_NOMINAL) period_est = vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic fill_phase(input int n, input int hlo, input int hhi, input int blo,
                            input int bhi, input int llo, input int lhi);
    int base;
    int pick;
    int w;
    int len;
    base = samples_made;
    while (samples_made - base < n) begin
      pick = $urandom_range(99);
      w = $urandom_range(hhi, hlo);
      if (pick < 70) begin
        len = $urandom_range(lhi, llo);
        push_run(w, 0, 3);
        push_run((len > w + 3) ? len - w : 3, 24, 63);
      end else if (pick < 78) begin
        len = $urandom_range(3 * lhi, w + 3);
        push_run(w, 0, 3);
        push_run(len - w, 24, 63);
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 2)) begin
          push_run($urandom_range(bhi, blo), 0, 3);
          push_run($urandom_range(llo / 2 + 3, 3), 24, 63);
        end
      end else if (pick < 92) begin
        push_run($urandom_range(bhi + 8, 1), 0, 3);
        push_run($urandom_range(lhi, 3), 24, 63);
      end else if (pick < 96) begin
        push_run($urandom_range(24, 1), 0, 63);
      end else begin
        push_run($urandom_range(5 * lhi, 3 * lhi), 24, 63);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = cvst_pkg::REG_HSYNC_MIN;
    cfg_wdata_i = '0;
    smp_if.valid = 1'b0;
    smp_if.payload = '0;
    res_if.ready = 1'b0;
    stall_cycles = 0;
    mismatches = 0;
    samples_made = 0;
    samples_sent = 0;
    beats_checked = 0;
    hsync_seen = 0;
    vsync_seen_cnt = 0;
    settings_used = 0;

    cfg_reg = '{cvst_pkg::HSYNC_MIN_RESET, cvst_pkg::HSYNC_MAX_RESET,
                cvst_pkg::BROAD_MIN_RESET, cvst_pkg::BROAD_MAX_RESET,
                cvst_pkg::LINE_MIN_RESET, cvst_pkg::LINE_MAX_RESET,
                cvst_pkg::NOMINAL_RESET, cvst_pkg::MAX_LINES_RESET};
    lvl_floor = cvst_pkg::FLOOR_RESET;
    lvl_peak = cvst_pkg::PEAK_RESET;
    pulse_len = 0;
    rise_run = 0;
    period_est = cvst_pkg::NOMINAL_RESET;
    score = 0;
    line_no = cvst_pkg::NO_LINE;
    smp_cnt = '0;
    pulse_origin = '0;
    last_h = '0;
    last_v = '0;
    in_pulse = 1'b0;
    v_seen = 1'b0;
    h_lock = 1'b0;
    v_lock = 1'b0;
    n_rejected = '0;
    n_loss = '0;
    n_gain = '0;

    src_idle_pct = 21;
    snk_idle_pct = 77;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_regs(2, 6, 10, 16, 20, 40, 30, 5);
    // hsync starting at index zero, then a broad pulse and a too-short pulse
    sample_q.push_back(8'h00);
    sample_q.push_back(8'hC0);
    sample_q.push_back(8'h83);
    sample_q.push_back(8'hFF);
    sample_q.push_back(8'h7F);
    sample_q.push_back(8'hBF);
    samples_made += 6;
    push_run(11, 0, 3);
    push_run(3, 24, 63);
    push_run(1, 0, 0);
    push_run(3, 63, 63);
    fill_phase(250, 2, 6, 10, 16, 20, 40);

    drain();
    program_regs(3, 8, 12, 24, 25, 45, 35, 12);
    fill_phase(250, 3, 8, 12, 24, 25, 45);

    drain();
    src_idle_pct = 77;
    snk_idle_pct = 21;
    // overlapping broad and horizontal ranges
    program_regs(2, 14, 10, 20, 20, 50, 32, 340);
    fill_phase(250, 2, 14, 10, 20, 20, 50);

    drain();
    program_regs(0, 0, 0, 0, 0, 0, 0, 0);
    fill_phase(250, 3, 8, 12, 24, 25, 45);

    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    program_regs(2047, 2047, 2047, 2047, 2047, 2047, 2047, 510);
    fill_phase(250, 3, 8, 12, 24, 25, 45);

    drain();
    // zero line period
    program_regs(1, 5, 8, 15, 15, 30, 0, 3);
    fill_phase(250, 1, 5, 8, 15, 15, 30);

    drain();
    program_regs(0, 2047, 2047, 0, 0, 2047, 2047, 510);
    fill_phase(250, 3, 8, 12, 24, 25, 45);

    drain();
    repeat (10) @(posedge clk_i);

    $display("checked %0d result beats for %0d samples over %0d register settings",
             beats_checked, samples_sent, settings_used);
    $display("seen %0d horizontal and %0d vertical events, %0d rejected, %0d gains, %0d losses",
             hsync_seen, vsync_seen_cnt, n_rejected, n_gain, n_loss);
    if (mismatches == 0) begin
      $display("composite_video_sync_tracker test passed");
    end else begin
      $display("composite_video_sync_tracker test failed");
    end
    $finish;
  end

endmodule
